FILE: sv/contiguous_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous page allocator
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// cond holds, then prop holds in the same cycle
`define CPA_ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("contiguous_page_allocator: check failed");

// cond holds, then prop holds in the next cycle
`define CPA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("contiguous_page_allocator: check failed");

`else

`define CPA_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define CPA_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: sv/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// Sizes
	localparam int MAX_PAGES = 1024;
	localparam int PAGE_W    = $clog2(MAX_PAGES);
	localparam int CNT_W     = 11;
	localparam int IDX_W     = 10;
	localparam int FLAG_W    = 4;
	localparam int STAT_W    = 3;

	localparam logic [CNT_W-1:0] PAGES_RESET = CNT_W'(1024);

	typedef logic [FLAG_W-1:0] flags_t;

	// Flag bits of a page
	localparam flags_t FLAG_USED   = 4'b0001;
	localparam flags_t FLAG_WIRED  = 4'b0010;
	localparam flags_t FLAG_HEAD   = 4'b0100;
	localparam flags_t FLAG_UNAVAIL = 4'b1000;

	// Command codes
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_MARK  = 2'd2;

	// Mark kinds
	localparam logic [1:0] KIND_AVAIL   = 2'd0;
	localparam logic [1:0] KIND_WIRED   = 2'd1;
	localparam logic [1:0] KIND_UNAVAIL = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_RUN    = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_PAGE  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_HEAD  = 3'd4;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_FILL,
		S_FREE,
		S_MARK,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [CNT_W-1:0] page_count;
		logic [IDX_W-1:0] page_index;
		logic [CNT_W-1:0] range_end;
		logic [1:0]       mark_kind;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  start_page;
	} res_t;

	typedef struct packed {
		logic              wr_en;
		logic [PAGE_W-1:0] wr_addr;
		flags_t            wr_data;
		logic              rd_en;
		logic [PAGE_W-1:0] rd_addr;
	} mem_req_t;

endpackage

FILE: sv/contiguous_page_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// Steps: an alloc decides, scans for a free run and fills it (no fill when
// no run fits); a free walks its run; a mark walks its range; rejects only decide.
// Throughput: one request at a time, one page per cycle through the flag RAM.
// Reset: a clearing pass marks every page unavailable; requests are
// stalled until it ends. Config writes are taken at any time.
// ----------------------------------------------------------------------------
`include "contiguous_page_allocator_macros.svh"

module contiguous_page_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [1:0]                 cmd,
	input  logic [cpa_pkg::CNT_W-1:0]  page_count,
	input  logic [cpa_pkg::IDX_W-1:0]  page_index,
	input  logic [cpa_pkg::CNT_W-1:0]  range_end,
	input  logic [1:0]                 mark_kind,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [cpa_pkg::STAT_W-1:0] status,
	output logic [cpa_pkg::IDX_W-1:0]  start_page,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cpa_pkg::CNT_W-1:0]  cfg_data
);

	import cpa_pkg::*;

	logic [CNT_W-1:0] pages_in_use_q;
	logic [CNT_W-1:0] nr;
	req_t             req;
	mem_req_t         mem;
	flags_t           rd_data;
	logic             eng_ready;
	logic             res_valid;
	res_t             res;
	logic             slot_free;
	logic             rsp_valid_q;
	res_t             rsp_q;

	// Page count register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_in_use_q <= PAGES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pages_in_use_q <= cfg_data;
		end
	end

	assign nr = (pages_in_use_q < CNT_W'(MAX_PAGES)) ? pages_in_use_q : CNT_W'(MAX_PAGES);

	// Request bundle
	always_comb begin
		req.cmd        = cmd;
		req.page_count = page_count;
		req.page_index = page_index;
		req.range_end  = range_end;
		req.mark_kind  = mark_kind;
	end

	assign req_stall = !eng_ready;

	cpa_flag_ram #(
		.DEPTH(MAX_PAGES),
		.WIDTH(FLAG_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (mem.wr_en),
		.wr_addr(mem.wr_addr),
		.wr_data(mem.wr_data),
		.rd_en  (mem.rd_en),
		.rd_addr(mem.rd_addr),
		.rd_data(rd_data)
	);

	cpa_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.nr       (nr),
		.req_valid(req_valid),
		.req_ready(eng_ready),
		.req      (req),
		.mem      (mem),
		.rd_data  (rd_data),
		.slot_free(slot_free),
		.res_valid(res_valid),
		.res      (res)
	);

	// Output register: holds one finished result while the next request runs
	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && slot_free) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = rsp_q.status;
	assign start_page = rsp_q.start_page;

	// Checks
	`CPA_ASSERT_SAME(a_no_rw_clash, clk, arst_n, mem.rd_en && mem.wr_en, mem.rd_addr != mem.wr_addr)
	`CPA_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && !req_stall, req_stall)
	`CPA_ASSERT_SAME(a_fail_zero_start, clk, arst_n, rsp_valid && status != ST_OK, start_page == '0)

endmodule

FILE: sv/cpa_flag_ram.sv
// ----------------------------------------------------------------------------
// cpa_flag_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cpa_flag_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/cpa_engine.sv
// ----------------------------------------------------------------------------
// cpa_engine
// Sequencer that walks the page flag memory: clearing pass, first-fit scan,
// run fill, and free walk and range mark by read-modify-write.
// ----------------------------------------------------------------------------
module cpa_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [cpa_pkg::CNT_W-1:0] nr,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  cpa_pkg::req_t             req,
	output cpa_pkg::mem_req_t         mem,
	input  cpa_pkg::flags_t           rd_data,
	input  logic                      slot_free,
	output logic                      res_valid,
	output cpa_pkg::res_t             res
);

	import cpa_pkg::*;

	state_t state_q, state_d;

	req_t              req_q;
	res_t              res_q;
	logic [CNT_W-1:0]  addr_s1;
	logic              rd_vld_s1;
	logic              first_pg_s1;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  run_q;
	logic [CNT_W-1:0]  first_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [PAGE_W-1:0] clr_q;

	logic [CNT_W-1:0]  idx_ext;
	logic [CNT_W-1:0]  nxt_addr;
	logic [CNT_W-1:0]  mark_stop;
	logic              mark_bad;
	logic              kind_bad;
	logic              al_walk;
	logic              fr_walk;
	logic              mk_walk;
	logic [STAT_W-1:0] dec_status;
	logic              scan_issue;
	logic              pg_free;
	logic [CNT_W-1:0]  run_inc;
	logic              scan_hit;
	logic              scan_miss;
	logic [CNT_W-1:0]  hit_start;
	logic              fr_head;
	logic              fr_used;
	logic              fr_bad;
	logic              fr_wr;
	logic              fr_cont;
	logic              fr_end;
	flags_t            mk_wdata;
	logic              mk_end;
	logic              clr_last;
	logic              fill_last;
	logic              req_acc;

	// Decisions shared by next state, outputs and datapath
	always_comb begin
		idx_ext   = CNT_W'(req_q.page_index);
		nxt_addr  = addr_s1 + CNT_W'(1);
		mark_stop = (req_q.range_end < nr) ? req_q.range_end : nr;
		mark_bad  = req_q.range_end > nr;
		kind_bad  = !(req_q.mark_kind == KIND_AVAIL || req_q.mark_kind == KIND_WIRED ||
			req_q.mark_kind == KIND_UNAVAIL);

		al_walk = (req_q.cmd == CMD_ALLOC) && (req_q.page_count <= nr) &&
			(req_q.page_count != '0);
		fr_walk = (req_q.cmd == CMD_FREE) && (idx_ext < nr);
		mk_walk = (req_q.cmd == CMD_MARK) && !kind_bad && (req_q.range_end > idx_ext) &&
			(idx_ext < mark_stop);

		unique case (req_q.cmd)
			CMD_ALLOC: dec_status = (req_q.page_count > nr) ? ST_TOO_LARGE : ST_NO_RUN;
			CMD_FREE:  dec_status = (idx_ext >= nr) ? ST_BAD_PAGE : ST_OK;
			CMD_MARK: begin
				if (kind_bad) begin
					dec_status = ST_BAD_PAGE;
				end else if (req_q.range_end <= idx_ext) begin
					dec_status = ST_OK;
				end else begin
					dec_status = mark_bad ? ST_BAD_PAGE : ST_OK;
				end
			end
			default:   dec_status = ST_OK;
		endcase

		// first-fit scan
		scan_issue = scan_q < nr;
		pg_free    = rd_data == '0;
		run_inc    = run_q + CNT_W'(1);
		scan_hit   = rd_vld_s1 && pg_free && (run_inc == req_q.page_count);
		scan_miss  = !rd_vld_s1 && !scan_issue;
		hit_start  = (run_q == '0) ? addr_s1 : first_q;

		// free walk
		fr_head  = (rd_data & FLAG_HEAD) != '0;
		fr_used  = (rd_data & FLAG_USED) != '0;
		fr_bad   = first_pg_s1 && !fr_head;
		fr_wr    = first_pg_s1 ? fr_head : (!fr_head && fr_used);
		fr_cont  = fr_wr && fr_used;
		fr_end   = !fr_cont || (nxt_addr >= nr);

		// range mark
		if (req_q.mark_kind == KIND_UNAVAIL) begin
			mk_wdata = rd_data | FLAG_UNAVAIL;
		end else if (req_q.mark_kind == KIND_WIRED) begin
			mk_wdata = (rd_data & ~FLAG_UNAVAIL) | FLAG_WIRED;
		end else begin
			mk_wdata = rd_data & ~FLAG_UNAVAIL;
		end
		mk_end = nxt_addr >= mark_stop;

		clr_last  = clr_q == PAGE_W'(MAX_PAGES - 1);
		fill_last = run_q == CNT_W'(1);
		req_acc   = (state_q == S_IDLE) && req_valid;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (clr_last) state_d = S_IDLE;
			S_IDLE:   if (req_acc) state_d = S_DECIDE;
			S_DECIDE: begin
				priority if (al_walk) state_d = S_SCAN;
				else if (fr_walk) state_d = S_FREE;
				else if (mk_walk) state_d = S_MARK;
				else state_d = S_RESULT;
			end
			S_SCAN: begin
				priority if (scan_hit) state_d = S_FILL;
				else if (scan_miss) state_d = S_RESULT;
				else state_d = S_SCAN;
			end
			S_FILL:   if (fill_last) state_d = S_RESULT;
			S_FREE:   if (fr_bad || fr_end) state_d = S_RESULT;
			S_MARK:   if (mk_end) state_d = S_RESULT;
			S_RESULT: if (slot_free) state_d = S_IDLE;
			default:  state_d = S_CLEAR;
		endcase
	end

	// Memory port and handshake outputs
	always_comb begin
		mem       = '0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		res       = res_q;
		unique case (state_q)
			S_CLEAR: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = clr_q;
				mem.wr_data = FLAG_UNAVAIL;
			end
			S_IDLE:   req_ready = 1'b1;
			S_DECIDE: begin
				mem.rd_en   = fr_walk || mk_walk;
				mem.rd_addr = req_q.page_index[PAGE_W-1:0];
			end
			S_SCAN: begin
				mem.rd_en   = scan_issue;
				mem.rd_addr = scan_q[PAGE_W-1:0];
			end
			S_FILL: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = ptr_q[PAGE_W-1:0];
				mem.wr_data = (ptr_q == first_q) ? (FLAG_USED | FLAG_HEAD) : FLAG_USED;
			end
			S_FREE: begin
				mem.wr_en   = fr_wr;
				mem.wr_addr = addr_s1[PAGE_W-1:0];
				mem.wr_data = rd_data & ~(FLAG_USED | FLAG_HEAD);
				mem.rd_en   = !fr_end;
				mem.rd_addr = nxt_addr[PAGE_W-1:0];
			end
			S_MARK: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = addr_s1[PAGE_W-1:0];
				mem.wr_data = mk_wdata;
				mem.rd_en   = !mk_end;
				mem.rd_addr = nxt_addr[PAGE_W-1:0];
			end
			S_RESULT: res_valid = 1'b1;
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			rd_vld_s1 <= 1'b0;
			clr_q     <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == S_SCAN) && scan_issue;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + PAGE_W'(1);
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) req_q <= req;
			end
			S_DECIDE: begin
				addr_s1        <= idx_ext;
				first_pg_s1    <= 1'b1;
				scan_q         <= '0;
				run_q          <= '0;
				res_q.status   <= dec_status;
				res_q.start_page <= '0;
			end
			S_SCAN: begin
				if (scan_issue) begin
					scan_q  <= scan_q + CNT_W'(1);
					addr_s1 <= scan_q;
				end
				if (scan_hit) begin
					ptr_q   <= hit_start;
					first_q <= hit_start;
					run_q   <= req_q.page_count;
				end else if (rd_vld_s1) begin
					if (pg_free) begin
						if (run_q == '0) first_q <= addr_s1;
						run_q <= run_inc;
					end else begin
						run_q <= '0;
					end
				end
			end
			S_FILL: begin
				ptr_q <= ptr_q + CNT_W'(1);
				run_q <= run_q - CNT_W'(1);
				if (fill_last) begin
					res_q.status     <= ST_OK;
					res_q.start_page <= first_q[IDX_W-1:0];
				end
			end
			S_FREE: begin
				first_pg_s1 <= 1'b0;
				addr_s1     <= nxt_addr;
				if (fr_bad) res_q.status <= ST_NOT_HEAD;
			end
			S_MARK:   addr_s1 <= nxt_addr;
			default: ;
		endcase
	end

endmodule
